[rtl/odwm_pkg.sv]
// ----------------------------------------------------------------------------
// Omni drive wheel mixer package
// Shared types, constants, the preset direction table and the sine table
// generator.
// ----------------------------------------------------------------------------
package odwm_pkg;

  // Fraction bits of the sine table entries (Q1.TRIG_FRAC_BITS).
  localparam int unsigned TRIG_FRAC_BITS = 15;

  localparam int unsigned NUM_WHEELS = 3;
  localparam int unsigned NUM_DIRS   = 12;
  localparam int unsigned NUM_LEVELS = 3;
  // Register stages from the command port to the result register.
  localparam int unsigned PIPE_DEPTH = 7;

  // Command codes.
  localparam logic       OP_PRESET = 1'b0;
  localparam logic       OP_POLAR  = 1'b1;
  localparam logic [6:0] STOP_CODE = 7'd88;

  // Heading correction.
  localparam logic [8:0] CORR_SPLIT = 9'd180;
  localparam logic [9:0] FULL_TURN  = 10'd360;

  // Travel angle offsets of wheels 0 and 2.
  localparam logic [9:0] WHEEL0_OFS = 10'd120;
  localparam logic [9:0] WHEEL2_OFS = 10'd60;

  // Dead-band map.
  localparam logic [9:0] DB_ZERO  = 10'd3;
  localparam logic [9:0] DB_KNEE  = 10'd70;
  localparam logic [9:0] DB_LOW_BASE  = 10'd25;
  localparam logic [9:0] DB_HIGH_BASE = 10'd60;
  localparam logic [5:0] DB_LOW_NUM   = 6'd35;   // over 67
  localparam logic [3:0] DB_HIGH_NUM  = 4'd13;   // 195/150 reduced to 13/10
  localparam logic [7:0] DUTY_MAX     = 8'd255;

  // Reciprocal multipliers. Each is ceil(2^shift / divisor); the operands seen
  // here stay well inside the range over which the floor is exact.
  localparam logic [12:0] Div100Mul   = 13'd5243;  // shift 19
  localparam int unsigned Div100Shift = 19;
  localparam logic [12:0] Div10Mul    = 13'd6554;  // shift 16
  localparam int unsigned Div10Shift  = 16;
  localparam logic [12:0] Div67Mul    = 13'd3913;  // shift 18
  localparam int unsigned Div67Shift  = 18;

  // Wheel 2 gain of 1.15 as 115 over 100.
  localparam logic [6:0] GAIN_NUM = 7'd115;

  // Width of the scaled product after the fraction bits are dropped.
  localparam int unsigned SCALED_W = 15;

  typedef enum logic [1:0] {
    MODE_PRESET = 2'd0,
    MODE_POLAR  = 2'd1,
    MODE_OFF    = 2'd2
  } mode_e;

  // What stage one hands to each wheel lane.
  typedef struct packed {
    mode_e              mode;
    logic signed [8:0]  corr;
    logic signed [8:0]  preset;
    logic [7:0]         spd;
    logic [8:0]         deg;
    logic               invert;
    logic               scale;
  } lane_in_t;

  // Preset wheel values: rows are level 3, level 2 and the low level.
  localparam int PRESET_TAB [NUM_LEVELS][NUM_DIRS][NUM_WHEELS] = '{
    '{'{-130, 0, 150}, '{-85, -85, 150}, '{0, -130, 150}, '{65, -120, 70},
      '{150, -130, 0}, '{120, -65, -70}, '{150, 0, -165}, '{80, 70, -150},
      '{0, 130, -150}, '{-70, 120, -80}, '{-140, 130, 0}, '{-120, 60, 70}},
    '{'{-80, 0, 95}, '{-45, -45, 95}, '{0, -80, 95}, '{40, -80, 55},
      '{90, -80, 0}, '{80, -40, -55}, '{90, 0, -105}, '{45, 40, -90},
      '{0, 80, -95}, '{-45, 80, -55}, '{-85, 80, 0}, '{-80, 40, 55}},
    '{'{-50, 0, 60}, '{-45, -45, 95}, '{0, -80, 95}, '{35, -60, 40},
      '{90, -80, 0}, '{80, -40, -55}, '{50, 0, -60}, '{45, 40, -90},
      '{0, 80, -95}, '{-35, 60, -40}, '{-85, 80, 0}, '{-80, 40, 55}}
  };

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Divides a Taylor term by (2k)(2k+1).
  function automatic logic [63:0] taylor_div(logic [63:0] term, int unsigned k);
    case (k)
      1:       return term / 64'd6;
      2:       return term / 64'd20;
      3:       return term / 64'd42;
      4:       return term / 64'd72;
      5:       return term / 64'd110;
      6:       return term / 64'd156;
      default: return term / 64'd210;
    endcase
  endfunction

  // sin(deg) for deg in 0..90, evaluated at elaboration with a fixed-point
  // Taylor series in Q30 and rounded half up to frac fraction bits.
  function automatic logic [31:0] sine_entry(int unsigned deg, int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] rnd;
    x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, k);
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    rnd = (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    return rnd[31:0];
  endfunction

endpackage

[rtl/odwm_cmd_if.sv]
// ----------------------------------------------------------------------------
// Omni drive command channel
// Valid/ready channel carrying one drive command item.
// ----------------------------------------------------------------------------
interface odwm_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [8:0] heading;
  logic [6:0] dir_code;
  logic [1:0] level;
  logic [7:0] speed;
  logic [8:0] angle;

  modport source (
    output valid, opcode, heading, dir_code, level, speed, angle,
    input  ready
  );
  modport sink (
    input  valid, opcode, heading, dir_code, level, speed, angle,
    output ready
  );
endinterface

[rtl/odwm_res_if.sv]
// ----------------------------------------------------------------------------
// Omni drive result channel
// Valid/ready channel carrying direction and duty for the three wheels.
// ----------------------------------------------------------------------------
interface odwm_res_if;
  logic       valid;
  logic       ready;
  logic       rev0;
  logic [7:0] duty0;
  logic       rev1;
  logic [7:0] duty1;
  logic       rev2;
  logic [7:0] duty2;

  modport source (
    output valid, rev0, duty0, rev1, duty1, rev2, duty2,
    input  ready
  );
  modport sink (
    input  valid, rev0, duty0, rev1, duty1, rev2, duty2,
    output ready
  );
endinterface

[rtl/odwm_lane.sv]
// ----------------------------------------------------------------------------
// Omni drive wheel lane
// Stages two to seven for one wheel: sine lookup, speed product, gain,
// heading correction, dead-band map and the result register.
// ----------------------------------------------------------------------------
module odwm_lane #(
  parameter int unsigned FracBits = odwm_pkg::TRIG_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  odwm_pkg::lane_in_t lane_i,
  output logic               rev_o,
  output logic [7:0]         duty_o
);

  localparam int unsigned MagW  = FracBits + 1;
  localparam int unsigned ProdW = MagW + 8;
  localparam int unsigned GainW = ProdW + 7;
  localparam int unsigned SclW  = odwm_pkg::SCALED_W;

  typedef struct packed {
    odwm_pkg::mode_e   mode;
    logic signed [8:0] corr;
    logic signed [8:0] preset;
    logic              neg;
    logic              scale;
  } lane_ctl_t;

  // Quarter-wave sine table, built at elaboration.
  logic [MagW-1:0] sin_tab [91];
  for (genvar g = 0; g < 91; g++) begin : g_sin
    assign sin_tab[g] = MagW'(odwm_pkg::sine_entry(g, FracBits));
  end

  // Stage 2: quadrant fold and table read.
  logic [6:0]      quad_idx;
  logic            quad_neg;
  lane_ctl_t       ctl2_d, ctl2_q;
  logic [MagW-1:0] mag2_q;
  logic [7:0]      spd2_q;

  always_comb begin
    if (lane_i.deg <= 9'd90) begin
      quad_idx = lane_i.deg[6:0];
      quad_neg = 1'b0;
    end else if (lane_i.deg <= 9'd180) begin
      quad_idx = 7'(9'd180 - lane_i.deg);
      quad_neg = 1'b0;
    end else if (lane_i.deg <= 9'd270) begin
      quad_idx = 7'(lane_i.deg - 9'd180);
      quad_neg = 1'b1;
    end else begin
      quad_idx = 7'(9'd360 - lane_i.deg);
      quad_neg = 1'b1;
    end
    ctl2_d.mode   = lane_i.mode;
    ctl2_d.corr   = lane_i.corr;
    ctl2_d.preset = lane_i.preset;
    ctl2_d.neg    = quad_neg ^ lane_i.invert;
    ctl2_d.scale  = lane_i.scale;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl2_q <= ctl2_d;
      mag2_q <= sin_tab[quad_idx];
      spd2_q <= lane_i.spd;
    end
  end

  // Stage 3: speed times sine magnitude.
  lane_ctl_t        ctl3_q;
  logic [ProdW-1:0] prod3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl3_q  <= ctl2_q;
      prod3_q <= ProdW'(spd2_q) * ProdW'(mag2_q);
    end
  end

  // Stage 4: drop the fraction bits, with the 115 gain first on wheel 2.
  lane_ctl_t       ctl4_q;
  logic [SclW-1:0] scl4_d, scl4_q;
  logic [GainW-1:0] gain4;

  always_comb begin
    gain4 = GainW'(prod3_q) * GainW'(odwm_pkg::GAIN_NUM);
    if (ctl3_q.scale) begin
      scl4_d = SclW'(gain4 >> FracBits);
    end else begin
      scl4_d = SclW'(prod3_q >> FracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl4_q <= ctl3_q;
      scl4_q <= scl4_d;
    end
  end

  // Stage 5: divide by 100 where scaled, apply the sign and the correction.
  odwm_pkg::mode_e    mode5_q;
  logic signed [10:0] x5_d, x5_q;
  logic [27:0]        rcp5;
  logic [8:0]         mag5;
  logic signed [10:0] mag5_s;
  logic signed [10:0] corr5_s;

  always_comb begin
    rcp5 = 28'(scl4_q) * 28'(odwm_pkg::Div100Mul);
    if (ctl4_q.scale) begin
      mag5 = 9'(rcp5 >> odwm_pkg::Div100Shift);
    end else begin
      mag5 = 9'(scl4_q);
    end
    mag5_s  = $signed({2'b00, mag5});
    corr5_s = 11'(ctl4_q.corr);
    if (ctl4_q.mode == odwm_pkg::MODE_PRESET) begin
      x5_d = 11'(ctl4_q.preset) + corr5_s;
    end else if (ctl4_q.neg) begin
      x5_d = corr5_s - mag5_s;
    end else begin
      x5_d = corr5_s + mag5_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode5_q <= ctl4_q.mode;
      x5_q    <= x5_d;
    end
  end

  // Stage 6: dead-band segment and its numerator.
  odwm_pkg::mode_e    mode6_q;
  logic signed [10:0] x6_q;
  logic [9:0]         abs6;
  logic [12:0]        num6_d, num6_q;
  logic               hi6_d, hi6_q, zero6_d, zero6_q;

  always_comb begin
    abs6    = x5_q[10] ? 10'(-x5_q) : 10'(x5_q);
    zero6_d = abs6 <= odwm_pkg::DB_ZERO;
    hi6_d   = abs6 > odwm_pkg::DB_KNEE;
    if (hi6_d) begin
      num6_d = 13'(abs6 - odwm_pkg::DB_KNEE) * 13'(odwm_pkg::DB_HIGH_NUM);
    end else begin
      num6_d = 13'(abs6 - odwm_pkg::DB_ZERO) * 13'(odwm_pkg::DB_LOW_NUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode6_q <= mode5_q;
      x6_q    <= x5_q;
      num6_q  <= num6_d;
      hi6_q   <= hi6_d;
      zero6_q <= zero6_d;
    end
  end

  // Stage 7: finish the map, saturate and drive the result register.
  logic [25:0] rcp7;
  logic [9:0]  mapped7;
  logic [7:0]  sat7;
  logic        rev_d, rev_q;
  logic [7:0]  duty_d, duty_q;

  always_comb begin
    if (hi6_q) begin
      rcp7    = 26'(num6_q) * 26'(odwm_pkg::Div10Mul);
      mapped7 = 10'(rcp7 >> odwm_pkg::Div10Shift) + odwm_pkg::DB_HIGH_BASE;
    end else begin
      rcp7    = 26'(num6_q) * 26'(odwm_pkg::Div67Mul);
      mapped7 = 10'(rcp7 >> odwm_pkg::Div67Shift) + odwm_pkg::DB_LOW_BASE;
    end
    if (zero6_q) begin
      sat7 = 8'd0;
    end else if (mapped7 > 10'(odwm_pkg::DUTY_MAX)) begin
      sat7 = odwm_pkg::DUTY_MAX;
    end else begin
      sat7 = mapped7[7:0];
    end

    rev_d  = 1'b0;
    duty_d = 8'd0;
    case (mode6_q)
      odwm_pkg::MODE_PRESET: begin
        // Preset values beyond full duty switch the wheel off.
        if (x6_q > 11'sd0 && x6_q <= 11'sd255) begin
          duty_d = x6_q[7:0];
        end else if (x6_q < 11'sd0 && x6_q >= -11'sd255) begin
          rev_d  = 1'b1;
          duty_d = 8'(-x6_q);
        end
      end
      odwm_pkg::MODE_POLAR: begin
        rev_d  = x6_q[10] && (sat7 != 8'd0);
        duty_d = sat7;
      end
      default: begin
        rev_d  = 1'b0;
        duty_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rev_q  <= rev_d;
      duty_q <= duty_d;
    end
  end

  assign rev_o  = rev_q;
  assign duty_o = duty_q;

endmodule

[rtl/omni_drive_wheel_mixer.sv]
// ----------------------------------------------------------------------------
// Omni drive wheel mixer
// Turns a drive command and a compass heading into direction and PWM duty
// for the three wheels of an omni drive base.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Item
//   cmd_i    in         valid/ready sink   opcode, heading, dir_code, level,
//                                          speed, angle
//   res_o    out        valid/ready source rev0/duty0, rev1/duty1, rev2/duty2
//
// The block is a seven-stage pipeline and accepts one item in every cycle
// while res_o does not stall it; a result appears once its command has passed every stage.
// The pipeline advances as a whole; when a result is held by a low
// res_o.ready, every stage freezes and cmd_i.ready drops, so nothing is lost
// or repeated. Empty stages do not stall the flow.
// Reset clears the valid bits only; no item is held after reset and no
// clearing pass is needed.
// A preset command with an unknown direction code is dropped at stage one and
// produces no result.
module omni_drive_wheel_mixer #(
  parameter int unsigned TrigFracBits = odwm_pkg::TRIG_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  odwm_cmd_if.sink   cmd_i,
  odwm_res_if.source res_o
);

  localparam int unsigned NumWheels = odwm_pkg::NUM_WHEELS;
  localparam int unsigned Depth     = odwm_pkg::PIPE_DEPTH;

  // The whole pipeline moves when the result register is empty or being
  // taken.
  logic             pipe_en;
  logic [Depth-1:0] vld_d, vld_q;

  assign pipe_en     = !vld_q[Depth-1] || res_o.ready;
  assign cmd_i.ready = pipe_en;

  // Stage 1: decode the command, form the heading correction, wrap the angle
  // and look up the preset table.
  logic              code_ok;
  logic [1:0]        row;
  logic [3:0]        dir;
  logic [9:0]        corr_full;
  logic signed [8:0] corr;
  logic [8:0]        ang;
  logic [9:0]        ang0_sum, ang2_sum;
  logic [8:0]        deg [NumWheels];
  odwm_pkg::mode_e   mode;

  odwm_pkg::lane_in_t lane_d [NumWheels];
  odwm_pkg::lane_in_t lane_q [NumWheels];

  always_comb begin
    code_ok = (cmd_i.opcode == odwm_pkg::OP_POLAR) ||
              (cmd_i.dir_code < 7'(odwm_pkg::NUM_DIRS)) ||
              (cmd_i.dir_code == odwm_pkg::STOP_CODE);

    // Level 3 selects the fast row, level 2 the middle row, else the low row.
    case (cmd_i.level)
      2'd3:    row = 2'd0;
      2'd2:    row = 2'd1;
      default: row = 2'd2;
    endcase
    dir = (cmd_i.dir_code < 7'(odwm_pkg::NUM_DIRS)) ? cmd_i.dir_code[3:0] : 4'd0;

    // Below 180 degrees the correction is minus the heading, otherwise the
    // distance to a full turn. Headings beyond a full turn give a negative
    // value through the same subtraction.
    if (cmd_i.heading < odwm_pkg::CORR_SPLIT) begin
      corr_full = 10'd0 - 10'(cmd_i.heading);
    end else begin
      corr_full = odwm_pkg::FULL_TURN - 10'(cmd_i.heading);
    end
    corr = $signed(corr_full[8:0]);

    ang = (10'(cmd_i.angle) >= odwm_pkg::FULL_TURN) ?
          9'(10'(cmd_i.angle) - odwm_pkg::FULL_TURN) : cmd_i.angle;
    ang0_sum = 10'(ang) + odwm_pkg::WHEEL0_OFS;
    ang2_sum = 10'(ang) + odwm_pkg::WHEEL2_OFS;
    deg[0] = (ang0_sum >= odwm_pkg::FULL_TURN) ?
             9'(ang0_sum - odwm_pkg::FULL_TURN) : ang0_sum[8:0];
    deg[1] = ang;
    deg[2] = (ang2_sum >= odwm_pkg::FULL_TURN) ?
             9'(ang2_sum - odwm_pkg::FULL_TURN) : ang2_sum[8:0];

    if (cmd_i.opcode == odwm_pkg::OP_PRESET) begin
      mode = odwm_pkg::MODE_PRESET;
    end else if (cmd_i.speed == 8'd0) begin
      // Zero speed turns every wheel off, correction included.
      mode = odwm_pkg::MODE_OFF;
    end else begin
      mode = odwm_pkg::MODE_POLAR;
    end
  end

  for (genvar w = 0; w < NumWheels; w++) begin : g_stage1
    always_comb begin
      lane_d[w].mode = mode;
      lane_d[w].corr = corr;
      // The stop code contributes nothing beyond the correction.
      if (cmd_i.opcode == odwm_pkg::OP_PRESET &&
          cmd_i.dir_code != odwm_pkg::STOP_CODE) begin
        lane_d[w].preset = 9'(odwm_pkg::PRESET_TAB[row][dir][w]);
      end else begin
        lane_d[w].preset = 9'sd0;
      end
      lane_d[w].spd    = cmd_i.speed;
      lane_d[w].deg    = deg[w];
      // Wheels 0 and 1 take the negated product, wheel 2 the 1.15 gain.
      lane_d[w].invert = (w != 2);
      lane_d[w].scale  = (w == 2);
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        lane_q[w] <= lane_d[w];
      end
    end
  end

  // Valid bits travel beside the data; a dropped command enters as a bubble.
  assign vld_d = {vld_q[Depth-2:0], cmd_i.valid && code_ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  // Stages 2 to 7, one lane per wheel.
  logic       rev  [NumWheels];
  logic [7:0] duty [NumWheels];

  for (genvar w = 0; w < NumWheels; w++) begin : g_lane
    odwm_lane #(
      .FracBits(TrigFracBits)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .lane_i(lane_q[w]),
      .rev_o (rev[w]),
      .duty_o(duty[w])
    );
  end

  assign res_o.valid = vld_q[Depth-1];
  assign res_o.rev0  = rev[0];
  assign res_o.duty0 = duty[0];
  assign res_o.rev1  = rev[1];
  assign res_o.duty1 = duty[1];
  assign res_o.rev2  = rev[2];
  assign res_o.duty2 = duty[2];

endmodule
